// ===== rtl/core/wtpc_pkg.sv =====
// ---------------------------------------------------------------------------
// Window threshold pixel counter: shared package
// Types, field widths, register indexes and reset values used across the
// counter's modules.
// ---------------------------------------------------------------------------
package wtpc_pkg;

	// Default store geometry.
	localparam int DEF_MAX_ROWS = 128;
	localparam int DEF_MAX_COLS = 128;

	// Field widths.
	localparam int PIX_W   = 8;
	localparam int POS_W   = 7;
	localparam int COUNT_W = 8;
	localparam int RAD_W   = 3;
	localparam int DIM_W   = 9;  // clamped image dimension, up to 255
	localparam int COORD_W = 8;  // window coordinate, up to 255

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_WINDOW_RADIUS    = 2'd0;
	localparam logic [1:0] REG_DETECT_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_IMAGE_ROWS       = 2'd2;
	localparam logic [1:0] REG_IMAGE_COLS       = 2'd3;

	// Register reset values.
	localparam logic [RAD_W-1:0] RST_WINDOW_RADIUS    = 3'd2;
	localparam logic [7:0]       RST_DETECT_THRESHOLD = 8'd0;
	localparam logic [7:0]       RST_IMAGE_ROWS       = 8'd128;
	localparam logic [7:0]       RST_IMAGE_COLS       = 8'd128;

	// Request kinds.
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Count reported for a position outside the image.
	localparam logic [COUNT_W-1:0] BAD_COUNT = 8'hff;

	// Largest count a clipped window can reach (15 by 15).
	localparam logic [COUNT_W-1:0] MAX_WINDOW_COUNT = 8'd225;

	// Geometry handed to the sequencer, already clamped to the store.
	typedef struct packed {
		logic [RAD_W-1:0] radius;
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
	} cfg_t;

	// Control from the sequencer to the counting unit.
	typedef struct packed {
		logic clear;   // start of a query: zero the count, take the threshold
		logic sample;  // a store read was issued this cycle
	} acc_ctrl_t;

	// Finished query waiting to be handed to the output register.
	typedef struct packed {
		logic             done;
		logic             invalid;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} seq_res_t;

endpackage

// ===== rtl/core/wtpc_ram.sv =====
// ---------------------------------------------------------------------------
// Window threshold pixel counter: generic single-port RAM
// One read or write per cycle, read data registered.
// ---------------------------------------------------------------------------
module wtpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/wtpc_acc.sv =====
// ---------------------------------------------------------------------------
// Window threshold pixel counter: counting unit
// Compares each pixel read from the store with the query threshold and
// counts those above it.
// ---------------------------------------------------------------------------
module wtpc_acc
	import wtpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  acc_ctrl_t          ctrl,
	input  logic [PIX_W-1:0]   threshold,
	input  logic [PIX_W-1:0]   rd_data,
	output logic [COUNT_W-1:0] count
);

	logic               sample_s1;
	logic [PIX_W-1:0]   thr_q;
	logic [COUNT_W-1:0] count_q;

	// Read data arrives in the cycle after the read was issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_s1 <= 1'b0;
			count_q   <= '0;
		end else begin
			sample_s1 <= ctrl.sample;
			if (ctrl.clear) begin
				count_q <= '0;
			end else if (sample_s1 && (rd_data > thr_q)) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			thr_q <= threshold;
		end
	end

	assign count = count_q;

endmodule

// ===== rtl/core/wtpc_seq.sv =====
// ---------------------------------------------------------------------------
// Window threshold pixel counter: window sequencer
// Checks the query position, clips the window to the image and walks its
// pixels one store read per cycle.
// ---------------------------------------------------------------------------
module wtpc_seq
	import wtpc_pkg::*;
#(
	parameter int ADDR_W = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	input  logic              in_query,
	input  logic [POS_W-1:0]  query_row,
	input  logic [POS_W-1:0]  query_col,
	output logic              ready,
	output logic [ADDR_W-1:0] walk_addr,
	output acc_ctrl_t         ctrl,
	output seq_res_t          res,
	input  logic              res_take
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_BOUND = 3'd1;
	localparam logic [2:0] ST_BASE  = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]         state_q;
	logic [POS_W-1:0]   qr_q, qc_q;
	logic [RAD_W-1:0]   rad_q;
	logic [DIM_W-1:0]   rows_q, cols_q;
	logic               inv_q;
	logic [COORD_W-1:0] r0_q, r1_q, c0_q, c1_q;
	logic [COORD_W-1:0] row_q, col_q;
	logic [ADDR_W-1:0]  row_base_q;

	logic               start;
	logic [COORD_W-1:0] qr_w, qc_w, rad_w;
	logic [COORD_W-1:0] r_hi_sum, c_hi_sum, r_lo, c_lo, r_hi, c_hi;
	logic               row_end, col_end;

	assign start = (state_q == ST_IDLE) && in_valid && (in_query == REQ_QUERY);

	// Window bounds, clipped to the image.
	always_comb begin
		qr_w     = COORD_W'(qr_q);
		qc_w     = COORD_W'(qc_q);
		rad_w    = COORD_W'(rad_q);
		r_lo     = (qr_w >= rad_w) ? (qr_w - rad_w) : '0;
		c_lo     = (qc_w >= rad_w) ? (qc_w - rad_w) : '0;
		r_hi_sum = qr_w + rad_w;
		c_hi_sum = qc_w + rad_w;
		r_hi     = (DIM_W'(r_hi_sum) > (rows_q - DIM_W'(1)))
			? COORD_W'(rows_q - DIM_W'(1)) : r_hi_sum;
		c_hi     = (DIM_W'(c_hi_sum) > (cols_q - DIM_W'(1)))
			? COORD_W'(cols_q - DIM_W'(1)) : c_hi_sum;
	end

	assign row_end = (row_q == r1_q);
	assign col_end = (col_q == c1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_BOUND;
					end
				end
				ST_BOUND: begin
					state_q <= inv_q ? ST_DONE : ST_BASE;
				end
				ST_BASE: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (col_end && row_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qr_q   <= query_row;
			qc_q   <= query_col;
			rad_q  <= cfg.radius;
			rows_q <= cfg.rows;
			cols_q <= cfg.cols;
			inv_q  <= (DIM_W'(query_row) >= cfg.rows) || (DIM_W'(query_col) >= cfg.cols);
		end
		if (state_q == ST_BOUND) begin
			r0_q <= r_lo;
			r1_q <= r_hi;
			c0_q <= c_lo;
			c1_q <= c_hi;
		end
		if (state_q == ST_BASE) begin
			// Operands widened first so the product keeps every address bit.
			row_base_q <= ADDR_W'(r0_q) * ADDR_W'(cols_q);
			row_q      <= r0_q;
			col_q      <= c0_q;
		end
		if (state_q == ST_WALK) begin
			if (col_end) begin
				col_q <= c0_q;
				if (!row_end) begin
					row_q      <= row_q + COORD_W'(1);
					row_base_q <= row_base_q + ADDR_W'(cols_q);
				end
			end else begin
				col_q <= col_q + COORD_W'(1);
			end
		end
	end

	assign ready       = (state_q == ST_IDLE);
	assign walk_addr   = row_base_q + ADDR_W'(col_q);
	assign ctrl.clear  = start;
	assign ctrl.sample = (state_q == ST_WALK);
	assign res.done    = (state_q == ST_DONE);
	assign res.invalid = inv_q;
	assign res.row     = qr_q;
	assign res.col     = qc_q;

endmodule

// ===== rtl/core/window_threshold_pixel_counter.sv =====
// A load request leaves the block ready. A query in the image has its bounds set,
// its first row address formed and its clipped window walked, W being the window's
// pixel count (1 to 225), one store read a cycle; a drain step lets the last read reach
// the count. Out-of-image queries skip the walk. One request is worked on at a time.
// Reset clears control state and sets the registers to their reset values; the image
// store is not cleared and holds nothing defined until loaded.
// ---------------------------------------------------------------------------
// Window threshold pixel counter
// Loads a grey image into a store and counts the pixels above a threshold in a
// square window around a queried position.
// ---------------------------------------------------------------------------
module window_threshold_pixel_counter
	import wtpc_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] pixel_value, [14:8] query_row, [21:15] query_col,
	// [29:22] pixel_threshold, [31:30] zero
	input  logic [31:0] s_axis_tdata,
	// [0] req_type
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [6:0] obj_row, [13:7] obj_col, [21:14] pixel_count, [22] detected,
	// [23] invalid
	output logic [23:0] m_axis_tdata
);

	localparam int STORE_SIZE = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

	// APB-style configuration registers: user writes only while idle, not enforced.
	logic [RAD_W-1:0] window_radius_q;
	logic [7:0]       detect_threshold_q;
	logic [7:0]       image_rows_q;
	logic [7:0]       image_cols_q;
	logic             cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_radius_q    <= RST_WINDOW_RADIUS;
			detect_threshold_q <= RST_DETECT_THRESHOLD;
			image_rows_q       <= RST_IMAGE_ROWS;
			image_cols_q       <= RST_IMAGE_COLS;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_WINDOW_RADIUS:    window_radius_q    <= pwdata[RAD_W-1:0];
				REG_DETECT_THRESHOLD: detect_threshold_q <= pwdata[7:0];
				REG_IMAGE_ROWS:       image_rows_q       <= pwdata[7:0];
				REG_IMAGE_COLS:       image_cols_q       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WINDOW_RADIUS:    prdata = 32'(window_radius_q);
			REG_DETECT_THRESHOLD: prdata = 32'(detect_threshold_q);
			REG_IMAGE_ROWS:       prdata = 32'(image_rows_q);
			REG_IMAGE_COLS:       prdata = 32'(image_cols_q);
			default:              prdata = '0;
		endcase
	end

	// Dimensions beyond the store are taken as the store's own size.
	cfg_t cfg;

	assign cfg.radius = window_radius_q;
	assign cfg.rows   = (DIM_W'(image_rows_q) > DIM_W'(MAX_ROWS))
		? DIM_W'(MAX_ROWS) : DIM_W'(image_rows_q);
	assign cfg.cols   = (DIM_W'(image_cols_q) > DIM_W'(MAX_COLS))
		? DIM_W'(MAX_COLS) : DIM_W'(image_cols_q);

	// Request fields.
	logic [PIX_W-1:0] pixel_value;
	logic [POS_W-1:0] query_row;
	logic [POS_W-1:0] query_col;
	logic [PIX_W-1:0] pixel_threshold;
	logic             req_accept;
	logic             load_we;

	assign pixel_value     = s_axis_tdata[7:0];
	assign query_row       = s_axis_tdata[14:8];
	assign query_col       = s_axis_tdata[21:15];
	assign pixel_threshold = s_axis_tdata[29:22];
	assign req_accept      = s_axis_tvalid && s_axis_tready;
	assign load_we         = req_accept && (s_axis_tuser == REQ_LOAD);

	// Load address: advances with each pixel and returns to zero after the
	// pixel marked last, or after the final entry of the store.
	logic [ADDR_W-1:0] load_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_addr_q <= '0;
		end else if (load_we) begin
			if (s_axis_tlast || (load_addr_q == ADDR_W'(STORE_SIZE - 1))) begin
				load_addr_q <= '0;
			end else begin
				load_addr_q <= load_addr_q + ADDR_W'(1);
			end
		end
	end

	// The sequencer walks the clipped window; the counting unit compares each
	// pixel as it comes back from the store.
	logic [ADDR_W-1:0]  walk_addr;
	acc_ctrl_t          acc_ctrl;
	seq_res_t           seq_res;
	logic               res_take;
	logic [PIX_W-1:0]   rd_data;
	logic [COUNT_W-1:0] count;

	wtpc_seq #(
		.ADDR_W (ADDR_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_query  (s_axis_tuser),
		.query_row (query_row),
		.query_col (query_col),
		.ready     (s_axis_tready),
		.walk_addr (walk_addr),
		.ctrl      (acc_ctrl),
		.res       (seq_res),
		.res_take  (res_take)
	);

	// The store has a single port: loads only happen while the sequencer is
	// idle, so the walk and the loads never contend.
	wtpc_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_SIZE)
	) u_store (
		.clk   (clk),
		.en    (load_we || acc_ctrl.sample),
		.we    (load_we),
		.addr  (acc_ctrl.sample ? walk_addr : load_addr_q),
		.wdata (pixel_value),
		.rdata (rd_data)
	);

	wtpc_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (acc_ctrl),
		.threshold (pixel_threshold),
		.rd_data   (rd_data),
		.count     (count)
	);

	// Output register: a finished result moves in as soon as the slot is free,
	// so the next request can be taken while this one waits downstream.
	logic               out_valid_q;
	logic [POS_W-1:0]   out_row_q;
	logic [POS_W-1:0]   out_col_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_detected_q;
	logic               out_invalid_q;

	assign res_take = seq_res.done && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_row_q      <= seq_res.row;
			out_col_q      <= seq_res.col;
			out_count_q    <= seq_res.invalid ? BAD_COUNT : count;
			out_detected_q <= !seq_res.invalid && (count > detect_threshold_q);
			out_invalid_q  <= seq_res.invalid;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_invalid_q, out_detected_q, out_count_q, out_col_q, out_row_q};

`ifndef SYNTH
	// A store read for the walk never happens while requests are being taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		acc_ctrl.sample |-> !s_axis_tready)
		else $error("window walk overlaps request acceptance");

	// An out-of-image result carries the fixed count and never detects.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[23]) |-> (!m_axis_tdata[22] &&
			(m_axis_tdata[21:14] == BAD_COUNT)))
		else $error("invalid result with detection or wrong count");

	// A valid window can never hold more than fifteen by fifteen pixels.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[23]) |-> (m_axis_tdata[21:14] <= MAX_WINDOW_COUNT))
		else $error("window count exceeds the largest window");
`endif

endmodule

// ===== verif/wtpc_count_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Window count checker
// Mirrors the register file and the image store of the pixel counter, works
// out the report due for every accepted query request and compares each
// accepted result with the oldest report still due.
// ---------------------------------------------------------------------------
module wtpc_count_checker
	import wtpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	output int          mismatches,
	output int          reports_due
);

	localparam int STORE_DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS;

	typedef struct packed {
		logic [POS_W-1:0]   row;
		logic [POS_W-1:0]   col;
		logic [COUNT_W-1:0] count;
		logic               detected;
		logic               invalid;
	} count_report_t;

	logic [PIX_W-1:0] image_copy [STORE_DEPTH];
	int               load_ptr = 0;
	logic [RAD_W-1:0] radius;
	logic [7:0]       detect_level;
	logic [7:0]       rows_reg;
	logic [7:0]       cols_reg;
	count_report_t    reports_q [$];
	int               fails = 0;
	int               due = 0;

	assign mismatches  = fails;
	assign reports_due = due;

	initial begin
		foreach (image_copy[k])
			image_copy[k] = '0;
	end

	// Count of pixels above the threshold in the clipped window around (row, col).
	function automatic count_report_t window_report(logic [POS_W-1:0] row,
			logic [POS_W-1:0] col, logic [PIX_W-1:0] level);
		count_report_t rep;
		int rows, cols, r, c, rad, r_lo, r_hi, c_lo, c_hi, hits;
		rows = (rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_reg);
		cols = (cols_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols_reg);
		r    = int'(row);
		c    = int'(col);
		rad  = int'(radius);
		rep.row = row;
		rep.col = col;
		if (r >= rows || c >= cols) begin
			rep.count    = BAD_COUNT;
			rep.detected = 1'b0;
			rep.invalid  = 1'b1;
			return rep;
		end
		r_lo = (r >= rad) ? r - rad : 0;
		c_lo = (c >= rad) ? c - rad : 0;
		r_hi = (r + rad > rows - 1) ? rows - 1 : r + rad;
		c_hi = (c + rad > cols - 1) ? cols - 1 : c + rad;
		hits = 0;
		for (int i = r_lo; i <= r_hi; i++)
			for (int j = c_lo; j <= c_hi; j++)
				if (image_copy[i * cols + j] > level)
					hits++;
		rep.count    = COUNT_W'(hits);
		rep.detected = (hits > int'(detect_level));
		rep.invalid  = 1'b0;
		return rep;
	endfunction

	task automatic check_report(input count_report_t got);
		count_report_t want;
		if (reports_q.size() == 0) begin
			$error("result with no query waiting: obj_row %0d obj_col %0d", got.row, got.col);
			fails++;
			return;
		end
		want = reports_q.pop_front();
		if (got.row !== want.row) begin
			$error("obj_row: expected %0d, got %0d", want.row, got.row);
			fails++;
		end
		if (got.col !== want.col) begin
			$error("obj_col: expected %0d, got %0d", want.col, got.col);
			fails++;
		end
		if (got.count !== want.count) begin
			$error("pixel_count: expected %0d, got %0d", want.count, got.count);
			fails++;
		end
		if (got.detected !== want.detected) begin
			$error("detected: expected %0d, got %0d", want.detected, got.detected);
			fails++;
		end
		if (got.invalid !== want.invalid) begin
			$error("invalid: expected %0d, got %0d", want.invalid, got.invalid);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		count_report_t got;
		if (!arst_n) begin
			radius       = RST_WINDOW_RADIUS;
			detect_level = RST_DETECT_THRESHOLD;
			rows_reg     = RST_IMAGE_ROWS;
			cols_reg     = RST_IMAGE_COLS;
			load_ptr     = 0;
			reports_q.delete();
			due          = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.row      = m_axis_tdata[6:0];
				got.col      = m_axis_tdata[13:7];
				got.count    = m_axis_tdata[21:14];
				got.detected = m_axis_tdata[22];
				got.invalid  = m_axis_tdata[23];
				check_report(got);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_WINDOW_RADIUS:    radius       = pwdata[RAD_W-1:0];
					REG_DETECT_THRESHOLD: detect_level = pwdata[7:0];
					REG_IMAGE_ROWS:       rows_reg     = pwdata[7:0];
					REG_IMAGE_COLS:       cols_reg     = pwdata[7:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == REQ_LOAD) begin
					image_copy[load_ptr] = s_axis_tdata[7:0];
					if (s_axis_tlast || load_ptr == STORE_DEPTH - 1)
						load_ptr = 0;
					else
						load_ptr++;
				end else begin
					reports_q.push_back(window_report(s_axis_tdata[14:8],
						s_axis_tdata[21:15], s_axis_tdata[29:22]));
				end
			end
			due = reports_q.size();
		end
	end

endmodule

// ===== verif/window_threshold_pixel_counter_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Window threshold pixel counter test
// Loads the top rows of the image store under the reset settings, runs a
// directed set of queries over the corner cases of the window and the register
// settings, then random phases of image loads and queries under random
// settings, with random gaps on both streams. Queries only ever reach store
// entries already loaded. A separate checker predicts every report and counts
// mismatches.
// ---------------------------------------------------------------------------
module window_threshold_pixel_counter_test;
	import wtpc_pkg::*;

	localparam int STORE_DEPTH     = DEF_MAX_ROWS * DEF_MAX_COLS;
	// Number of random requests after the directed part, and the point after
	// which both streams run without gaps.
	localparam int RANDOM_REQUESTS = 1270;
	localparam int QUIET_FROM      = 1100;
	// Watchdog limit, set with a wide margin over the slowest correct run.
	localparam int CYCLE_LIMIT     = 3000000;
	// Longer than a query of the largest window lasts, so a stray report
	// would surface within this wait after the last expected one.
	localparam int DRAIN_CYCLES    = 250;
	// A load may still be in flight when the last report has come back.
	localparam int SETTLE_CYCLES   = 8;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;

	int          mismatches;
	int          reports_due;
	int          requests_sent = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;
	// Image size and radius as the block sees them; used to aim queries.
	int          cur_rows = DEF_MAX_ROWS;
	int          cur_cols = DEF_MAX_COLS;
	int          cur_rad = int'(RST_WINDOW_RADIUS);
	// Loads fill the store from address zero upwards, so the entries loaded
	// since reset always form one block starting at zero.
	int          load_ptr = 0;
	int          written = 0;

	window_threshold_pixel_counter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	wtpc_count_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.reports_due   (reports_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake or a report that never comes ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side back-pressure. Random stalls come between stretches of ready
	// cycles, so they land on every phase of a query, and they stop once the
	// run goes quiet.
	initial begin
		m_axis_tready = 1'b1;
		forever begin
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	// One register write: a setup phase, then the access phase held until
	// pready. The unused upper bits of the write data carry random junk, which
	// the block must ignore. A wait for the clock follows so that back-to-back writes
	// never assign psel twice in one time step.
	task automatic write_register(input logic [1:0] index, input logic [7:0] value);
		logic [31:0] junk;
		logic        rdy;
		junk    = $urandom;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= (index == REG_WINDOW_RADIUS) ? {junk[31:RAD_W], value[RAD_W-1:0]}
		                                        : {junk[31:8], value};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [2:0] rad, input logic [7:0] det,
			input logic [7:0] rows, input logic [7:0] cols);
		write_register(REG_WINDOW_RADIUS, {5'd0, rad});
		write_register(REG_DETECT_THRESHOLD, det);
		write_register(REG_IMAGE_ROWS, rows);
		write_register(REG_IMAGE_COLS, cols);
		cur_rows = (rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows);
		cur_cols = (cols > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols);
		cur_rad  = int'(rad);
	endtask

	// Hand one request to the block. Before it the sender may idle for a random
	// burst. Acceptance is judged from tready as it stands at the falling edge,
	// which is the value the block sees at the next rising edge.
	task automatic issue(input logic kind, input logic [7:0] pix, input logic last,
			input logic [6:0] row, input logic [6:0] col, input logic [7:0] thr);
		logic took;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tlast  <= last;
		s_axis_tdata  <= {2'b00, thr, col, row, pix};
		do begin
			@(negedge clk);
			took = s_axis_tready;
			@(posedge clk);
		end while (!took);
		requests_sent++;
	endtask

	// Fields that a request kind does not use are filled with random values.
	task automatic load_pixel(input logic [7:0] pix, input logic last);
		issue(REQ_LOAD, pix, last, 7'($urandom), 7'($urandom), 8'($urandom));
		if (load_ptr + 1 > written)
			written = load_ptr + 1;
		load_ptr = (last || load_ptr == STORE_DEPTH - 1) ? 0 : load_ptr + 1;
	endtask

	task automatic query(input logic [6:0] row, input logic [6:0] col, input logic [7:0] thr);
		issue(REQ_QUERY, 8'($urandom), 1'($urandom), row, col, thr);
	endtask

	// A query is safe when it lies outside the image or when the last pixel
	// of its clipped window, its highest address, has been loaded.
	function automatic bit query_safe(input logic [6:0] row, input logic [6:0] col);
		int r1;
		int c1;
		if (int'(row) >= cur_rows || int'(col) >= cur_cols)
			return 1'b1;
		r1 = (int'(row) + cur_rad > cur_rows - 1) ? cur_rows - 1 : int'(row) + cur_rad;
		c1 = (int'(col) + cur_rad > cur_cols - 1) ? cur_cols - 1 : int'(col) + cur_rad;
		return (r1 * cur_cols + c1 < written);
	endfunction

	// Stop sending and wait until every report due has come back, then allow
	// for a load that may still be in progress. Registers are only written
	// after this.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (reports_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Image dimension for a random phase: mostly small images so that loads
	// stay short, with zero, the store size and values above it now and then.
	function automatic logic [7:0] pick_dim();
		case ($urandom_range(0, 19))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd128;
			3:       return 8'($urandom_range(129, 255));
			4, 5, 6: return 8'($urandom_range(17, 127));
			default: return 8'($urandom_range(1, 16));
		endcase
	endfunction

	function automatic logic [7:0] pick_threshold();
		case ($urandom_range(0, 9))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int          base;
		int          size;
		int          n;
		int          nq;
		int          hi_row;
		bit          found;
		logic [2:0]  rad;
		logic [7:0]  det;
		logic [6:0]  row;
		logic [6:0]  col;

		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = REQ_LOAD;
		s_axis_tlast  = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load the first three rows of a 128 column image under the reset
		// settings, the last pixel marked so the load address returns to zero.
		// The first two pixels are the extremes of the pixel range.
		for (int k = 0; k < 3 * DEF_MAX_COLS; k++)
			load_pixel((k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom),
				k == 3 * DEF_MAX_COLS - 1);

		// Directed queries under the reset settings: radius 2, 128 by 128.
		// Along the top row the window covers rows 0 to 2 only; the corners
		// clip it on two sides, and threshold 255 can never count.
		query(7'd0, 7'd0, 8'd0);
		query(7'd0, 7'd127, 8'd255);
		query(7'd0, 7'd127, 8'd127);
		query(7'd0, 7'd64, 8'd100);
		query(7'd0, 7'd1, 8'd128);

		// A 15 by 15 image of full-scale pixels: the widest window sees all of
		// it, which gives the largest count and a detection just above 224.
		// The load address restarts at zero after the last marker above.
		settle();
		configure(3'd7, 8'd224, 8'd15, 8'd15);
		for (int k = 0; k < 225; k++)
			load_pixel(8'd255, k == 224);
		query(7'd7, 7'd7, 8'd0);
		query(7'd7, 7'd7, 8'd254);
		query(7'd7, 7'd7, 8'd255);
		query(7'd14, 7'd0, 8'd0);
		// Row and column equal to the image size lie outside it.
		query(7'd15, 7'd3, 8'd0);
		query(7'd3, 7'd15, 8'd0);

		// Zero columns make every query invalid, whatever the row.
		settle();
		configure(3'd0, 8'd255, 8'd255, 8'd0);
		query(7'd5, 7'd5, 8'd0);

		// Zero rows likewise.
		settle();
		configure(3'd3, 8'd0, 8'd0, 8'd200);
		query(7'd0, 7'd0, 8'd0);

		// Sizes above the store are taken as the store size. A single-pixel
		// window at the end of the third row, which is the last pixel loaded
		// only when the columns are taken as 128; then a dark pixel marked
		// last at address zero, which must not count at threshold zero.
		settle();
		configure(3'd0, 8'd0, 8'd200, 8'd255);
		query(7'd2, 7'd127, 8'd0);
		load_pixel(8'd0, 1'b1);
		query(7'd0, 7'd0, 8'd0);

		// A one-pixel image under the widest radius.
		settle();
		configure(3'd7, 8'd0, 8'd1, 8'd1);
		query(7'd0, 7'd0, 8'd255);
		query(7'd0, 7'd1, 8'd0);

		// Random phases. Each one starts from an idle block with new settings,
		// usually loads a fresh image with the last pixel marked, then runs a
		// burst of queries, mostly inside the loaded part of the image, with the
		// odd stray load. A query that would reach past the loaded part is
		// replaced by another load.
		base = requests_sent;
		while (requests_sent - base < RANDOM_REQUESTS) begin
			settle();
			quiet = (requests_sent - base >= QUIET_FROM);
			rad = 3'($urandom_range(0, 7));
			case ($urandom_range(0, 9))
				0:       det = 8'd0;
				1:       det = 8'd255;
				default: det = 8'($urandom_range(0, 40));
			endcase
			configure(rad, det, pick_dim(), pick_dim());

			size = cur_rows * cur_cols;
			if ($urandom_range(0, 2) != 0) begin
				// Large images are loaded only in part to keep phases short.
				n = (size > 256) ? 256 : size;
				for (int k = 0; k < n; k++)
					load_pixel(8'($urandom), k == size - 1);
			end

			nq = $urandom_range(20, 60);
			for (int k = 0; k < nq; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					load_pixel(8'($urandom), $urandom_range(0, 7) == 0);
				end else begin
					found = 1'b0;
					for (int t = 0; t < 8 && !found; t++) begin
						if (cur_rows != 0 && cur_cols != 0 && $urandom_range(0, 4) != 0) begin
							hi_row = written / cur_cols;
							if (hi_row > cur_rows - 1)
								hi_row = cur_rows - 1;
							row = 7'($urandom_range(0, hi_row));
							col = 7'($urandom_range(0, cur_cols - 1));
						end else begin
							row = 7'($urandom_range(0, 127));
							col = 7'($urandom_range(0, 127));
						end
						found = query_safe(row, col);
					end
					if (found)
						query(row, col, pick_threshold());
					else
						load_pixel(8'($urandom), 1'b0);
				end
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/wtpc_pkg.sv
rtl/core/wtpc_ram.sv
rtl/core/wtpc_acc.sv
rtl/core/wtpc_seq.sv
rtl/core/window_threshold_pixel_counter.sv
verif/wtpc_count_checker.sv
verif/window_threshold_pixel_counter_test.sv
